[src/atpr_pkg.sv]
package atpr_pkg;

   // Field widths and fixed-point layout
   localparam int AXIS_BITS        = 16;
   localparam int ANGLE_FRAC_BITS  = 8;
   localparam int PITCH_W          = 17;
   localparam int ROLL_W           = 16;
   localparam int WORK_W           = 64;
   localparam int WORK_FRAC        = 24;
   localparam int ANG_W            = 35;
   localparam int CORDIC_STEPS     = 28;
   localparam int AXIS_SCALE_SHIFT = 60 - AXIS_BITS;
   localparam int ROUND_SHIFT      = WORK_FRAC - ANGLE_FRAC_BITS;
   localparam int GAIN_FRAC        = 30;

   typedef logic signed [AXIS_BITS-1:0] axis_type;
   typedef logic signed [PITCH_W-1:0]   pitch_type;
   typedef logic signed [ROLL_W-1:0]    roll_type;
   typedef logic signed [WORK_W-1:0]    work_type;
   typedef logic signed [ANG_W-1:0]     angle_type;

   // 1/K of the CORDIC in Q30
   localparam logic [GAIN_FRAC-1:0] INV_GAIN = GAIN_FRAC'(652032874);

   localparam angle_type ANG_P180 = angle_type'(longint'(180) * (longint'(1) <<< WORK_FRAC));
   localparam angle_type ANG_HALF = angle_type'(longint'(1) <<< (ROUND_SHIFT - 1));

   localparam pitch_type PITCH_P180 = pitch_type'(180 * (2 ** ANGLE_FRAC_BITS));
   localparam pitch_type PITCH_P90  = pitch_type'(90 * (2 ** ANGLE_FRAC_BITS));
   localparam pitch_type PITCH_N90  = pitch_type'(-90 * (2 ** ANGLE_FRAC_BITS));
   localparam roll_type  ROLL_P90   = roll_type'(90 * (2 ** ANGLE_FRAC_BITS));
   localparam roll_type  ROLL_N90   = roll_type'(-90 * (2 ** ANGLE_FRAC_BITS));

   // atan(2^-i) in units of 2^-24 degree
   localparam angle_type STEP_ANGLE [CORDIC_STEPS] = '{
      angle_type'(754974720), angle_type'(445687602), angle_type'(235489088),
      angle_type'(119537938), angle_type'(60000934),  angle_type'(30029717),
      angle_type'(15018523),  angle_type'(7509720),   angle_type'(3754917),
      angle_type'(1877466),   angle_type'(938734),    angle_type'(469367),
      angle_type'(234684),    angle_type'(117342),    angle_type'(58671),
      angle_type'(29335),     angle_type'(14668),     angle_type'(7334),
      angle_type'(3667),      angle_type'(1833),      angle_type'(917),
      angle_type'(458),       angle_type'(229),       angle_type'(115),
      angle_type'(57),        angle_type'(29),        angle_type'(14),
      angle_type'(7)
   };

   typedef struct packed {
      work_type  x;
      work_type  y;
      angle_type a;
   } cordic_type;

   // Sample info carried alongside the pitch rotation
   typedef struct packed {
      work_type roll_y;
      logic     y_zero;
      logic     z_zero;
      logic     z_neg;
      logic     y_pos;
      logic     x_pos;
      logic     x_neg;
   } pside_type;

   // Info carried alongside the roll rotation
   typedef struct packed {
      pitch_type pitch;
      logic      yz_zero;
      logic      x_pos;
      logic      x_neg;
   } rside_type;

   typedef struct packed {
      pitch_type pitch;
      roll_type  roll;
   } res_type;

   // Sign-extend an axis sample into bits 59..44 of the working word
   function automatic work_type axis_scale(input axis_type v);
      work_type w;
      w = work_type'(v);
      return w <<< AXIS_SCALE_SHIFT;
   endfunction

   // One vectoring micro-rotation, driving y toward zero
   function automatic cordic_type cordic_step(input cordic_type s, input int unsigned sh,
                                              input angle_type step);
      cordic_type n;
      work_type   dx;
      work_type   dy;
      dx = s.y >>> sh;
      dy = s.x >>> sh;
      if (!s.y[WORK_W-1]) begin
         n.x = s.x + dx;
         n.y = s.y - dy;
         n.a = s.a + step;
      end else begin
         n.x = s.x - dx;
         n.y = s.y + dy;
         n.a = s.a - step;
      end
      return n;
   endfunction

   // Round to nearest, halves up, and keep the field width
   function automatic pitch_type round_pitch(input angle_type a);
      angle_type s;
      s = a + ANG_HALF;
      return pitch_type'(s[ROUND_SHIFT +: PITCH_W]);
   endfunction

   function automatic roll_type round_roll(input angle_type a);
      angle_type s;
      s = a + ANG_HALF;
      return roll_type'(s[ROUND_SHIFT +: ROLL_W]);
   endfunction

endpackage

[src/atpr_req_if.sv]
interface atpr_req_if;
   logic               valid;
   logic               ready;
   atpr_pkg::axis_type accel_x;
   atpr_pkg::axis_type accel_y;
   atpr_pkg::axis_type accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                   output ready);
endinterface

[src/atpr_rsp_if.sv]
interface atpr_rsp_if;
   logic                valid;
   logic                ready;
   atpr_pkg::pitch_type pitch_deg;
   atpr_pkg::roll_type  roll_deg;

   modport source (output valid, output pitch_deg, output roll_deg, input ready);
   modport sink   (input valid, input pitch_deg, input roll_deg, output ready);
endinterface

[src/accel_tilt_pitch_roll.sv]
// Accelerometer tilt: pitch = atan2(Y, Z) over the full circle and
// roll = atan2(X, sqrt(Y^2 + Z^2)) in -90..+90, both in 1/256 degree.
// req_chan carries one three-axis sample per word; rsp_chan returns one word
// with pitch_deg and roll_deg for every sample, in order.
// Throughput: one word per cycle while not stalled. The datapath is a
// 28-stage pitch CORDIC, a magnitude-correction multiply stage, an add
// stage and a 28-stage roll CORDIC; every stage holds one word, so a new
// sample enters each cycle. rsp_chan.valid rises once an accepted sample
// has passed the entry register, the pitch chain, the multiply and add
// registers and the roll chain and is loaded into the output register.
// Stall: the result sits in an output register backed by one skid register.
// When the receiver holds off and the skid register fills, the whole
// pipeline freezes and req_chan.ready drops; req_chan.ready depends only on
// registered state, never on rsp_chan.ready in the same cycle.
// Reset (synchronous, active high) clears every valid bit, including those
// of the output and skid registers; the block carries no other state
// between samples.
module accel_tilt_pitch_roll (
   input logic        clock,
   input logic        reset,
   atpr_req_if.sink   req_chan,
   atpr_rsp_if.source rsp_chan
);

   localparam int NS    = atpr_pkg::CORDIC_STEPS;
   localparam int VLD_N = 2 * NS + 3;
   localparam int HI_W  = atpr_pkg::WORK_W - 1 - atpr_pkg::GAIN_FRAC;
   localparam int GF    = atpr_pkg::GAIN_FRAC;

   logic en;
   logic take;
   logic push;
   logic pop;

   logic [VLD_N-1:0] vld_ff;

   atpr_pkg::cordic_type p_ff  [0:NS];
   atpr_pkg::cordic_type p_in  [0:NS];
   atpr_pkg::pside_type  ps_ff [0:NS];
   atpr_pkg::pside_type  ps_in;

   logic [HI_W-1:0]      mag_hi;
   logic [HI_W+GF-1:0]   m_hi_in;
   logic [HI_W+GF-1:0]   m_hi_ff;
   logic [2*GF-1:0]      m_lo_in;
   logic [2*GF-1:0]      m_lo_ff;
   logic [atpr_pkg::WORK_W-1:0] mag;
   atpr_pkg::work_type   m_roll_y_ff;
   atpr_pkg::rside_type  m_side_in;
   atpr_pkg::rside_type  m_side_ff;

   atpr_pkg::cordic_type r_ff  [0:NS];
   atpr_pkg::cordic_type r_in  [0:NS];
   atpr_pkg::rside_type  rs_ff [0:NS];

   atpr_pkg::res_type res;
   atpr_pkg::res_type out_ff;
   atpr_pkg::res_type out_in;
   atpr_pkg::res_type skid_ff;
   atpr_pkg::res_type skid_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              skid_valid_ff;
   logic              skid_valid_in;

   // Pipeline moves whenever the skid register is free
   assign en             = !skid_valid_ff;
   assign req_chan.ready = en;
   assign take           = req_chan.valid & en;
   assign push           = vld_ff[VLD_N-1] & en;
   assign pop            = out_valid_ff & rsp_chan.ready;

   // Entry: scale the axes, fold Z < 0 into the right half-plane
   always_comb begin
      atpr_pkg::work_type ay_w;
      atpr_pkg::work_type az_w;
      ay_w = atpr_pkg::axis_scale(req_chan.accel_y);
      az_w = atpr_pkg::axis_scale(req_chan.accel_z);
      if (req_chan.accel_z[atpr_pkg::AXIS_BITS-1]) begin
         p_in[0].x = -az_w;
         p_in[0].y = -ay_w;
         p_in[0].a = req_chan.accel_y[atpr_pkg::AXIS_BITS-1] ? -atpr_pkg::ANG_P180
                                                              : atpr_pkg::ANG_P180;
      end else begin
         p_in[0].x = az_w;
         p_in[0].y = ay_w;
         p_in[0].a = '0;
      end
      ps_in.roll_y = atpr_pkg::axis_scale(req_chan.accel_x);
      ps_in.y_zero = (req_chan.accel_y == '0);
      ps_in.z_zero = (req_chan.accel_z == '0);
      ps_in.z_neg  = req_chan.accel_z[atpr_pkg::AXIS_BITS-1];
      ps_in.y_pos  = !req_chan.accel_y[atpr_pkg::AXIS_BITS-1] && (req_chan.accel_y != '0);
      ps_in.x_pos  = !req_chan.accel_x[atpr_pkg::AXIS_BITS-1] && (req_chan.accel_x != '0);
      ps_in.x_neg  = req_chan.accel_x[atpr_pkg::AXIS_BITS-1];
   end

   // Pitch rotation chain, one micro-rotation per stage
   for (genvar i = 0; i < NS; i++) begin : g_pitch
      assign p_in[i+1] = atpr_pkg::cordic_step(p_ff[i], i, atpr_pkg::STEP_ANGLE[i]);
   end

   // Magnitude times 1/K, split into two partial products; pitch rounding
   assign mag     = (p_ff[NS].x > 0) ? p_ff[NS].x : '0;
   assign mag_hi  = mag[atpr_pkg::WORK_W-2:GF];
   assign m_hi_in = mag_hi * atpr_pkg::INV_GAIN;
   assign m_lo_in = mag[GF-1:0] * atpr_pkg::INV_GAIN;

   always_comb begin
      if (ps_ff[NS].y_zero) begin
         m_side_in.pitch = ps_ff[NS].z_neg ? atpr_pkg::PITCH_P180 : '0;
      end else if (ps_ff[NS].z_zero) begin
         m_side_in.pitch = ps_ff[NS].y_pos ? atpr_pkg::PITCH_P90 : atpr_pkg::PITCH_N90;
      end else begin
         m_side_in.pitch = atpr_pkg::round_pitch(p_ff[NS].a);
      end
      m_side_in.yz_zero = ps_ff[NS].y_zero & ps_ff[NS].z_zero;
      m_side_in.x_pos   = ps_ff[NS].x_pos;
      m_side_in.x_neg   = ps_ff[NS].x_neg;
   end

   // Roll start: corrected magnitude against scaled X
   assign r_in[0].x = atpr_pkg::work_type'(atpr_pkg::WORK_W'(m_hi_ff)
                                         + atpr_pkg::WORK_W'(m_lo_ff >> GF));
   assign r_in[0].y = m_roll_y_ff;
   assign r_in[0].a = '0;

   // Roll rotation chain
   for (genvar j = 0; j < NS; j++) begin : g_roll
      assign r_in[j+1] = atpr_pkg::cordic_step(r_ff[j], j, atpr_pkg::STEP_ANGLE[j]);
   end

   // Final roll rounding and special cases
   always_comb begin
      res.pitch = rs_ff[NS].pitch;
      if (rs_ff[NS].yz_zero) begin
         if (rs_ff[NS].x_pos) begin
            res.roll = atpr_pkg::ROLL_P90;
         end else if (rs_ff[NS].x_neg) begin
            res.roll = atpr_pkg::ROLL_N90;
         end else begin
            res.roll = '0;
         end
      end else begin
         res.roll = atpr_pkg::round_roll(r_ff[NS].a);
      end
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[VLD_N-2:0], take};
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff        <= p_in;
         ps_ff[0]    <= ps_in;
         for (int k = 0; k < NS; k++) begin
            ps_ff[k+1] <= ps_ff[k];
            rs_ff[k+1] <= rs_ff[k];
         end
         m_hi_ff     <= m_hi_in;
         m_lo_ff     <= m_lo_in;
         m_roll_y_ff <= ps_ff[NS].roll_y;
         m_side_ff   <= m_side_in;
         r_ff        <= r_in;
         rs_ff[0]    <= m_side_ff;
      end
   end

   // Output register with one skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_in       = res;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.pitch_deg = out_ff.pitch;
   assign rsp_chan.roll_deg  = out_ff.roll;

   // Skid entry is only ever filled behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word present without output word");

   // A full skid entry blocks new pipeline output
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> !(skid_valid_ff && $past(skid_valid_ff) && !$past(pop)) || !push)
      else $error("pipeline advanced into full output buffer");

   // Angles stay within their ranges
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.pitch_deg <= atpr_pkg::PITCH_P180)
                      && (rsp_chan.pitch_deg >= -atpr_pkg::PITCH_P180))
      else $error("pitch out of range");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.roll_deg <= atpr_pkg::ROLL_P90)
                      && (rsp_chan.roll_deg >= atpr_pkg::ROLL_N90))
      else $error("roll out of range");

endmodule

[dv/tb_accel_tilt_pitch_roll.sv]
module tb_accel_tilt_pitch_roll;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int RANDOM_WORDS  = 550;
   localparam int HOLD_AT_WORD  = 150;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_AT_WORD = 320;
   localparam int TAIL_CYCLES   = 80;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTS   = 10;
   localparam int DIR_ROWS      = 22;

   localparam longint unsigned INV_GAIN_Q30 = 64'd652032874;
   localparam longint ONE_DEG      = longint'(1) <<< atpr_pkg::ANGLE_FRAC_BITS;
   localparam longint WORK_ONE_DEG = longint'(1) <<< atpr_pkg::WORK_FRAC;
   localparam longint ROUND_HALF   = longint'(1) <<< (atpr_pkg::ROUND_SHIFT - 1);

   // atan(2^-i) in 2^-24 degree
   localparam longint ATAN_STEP [atpr_pkg::CORDIC_STEPS] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
      117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
      115, 57, 29, 14, 7
   };

   localparam atpr_pkg::axis_type EXTREME_VALS [7] = '{
      16'sh8000, 16'sh8001, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFE, 16'sh7FFF
   };

   typedef struct packed {
      atpr_pkg::axis_type  x;
      atpr_pkg::axis_type  y;
      atpr_pkg::axis_type  z;
      logic                known;
      atpr_pkg::pitch_type pitch;
      atpr_pkg::roll_type  roll;
   } tilt_row_type;

   // directed samples; known rows carry the exact angles of the saturating cases
   localparam tilt_row_type DIRECTED [DIR_ROWS] = '{
      '{16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 17'sd0, 16'sd0},
      '{16'sh7FFF, 16'sh0000, 16'sh0000, 1'b1, 17'sd0, 16'sd23040},
      '{16'sh8000, 16'sh0000, 16'sh0000, 1'b1, 17'sd0, -16'sd23040},
      '{16'sh0001, 16'sh0000, 16'sh0000, 1'b1, 17'sd0, 16'sd23040},
      '{16'shFFFF, 16'sh0000, 16'sh0000, 1'b1, 17'sd0, -16'sd23040},
      '{16'sh0000, 16'sh0000, 16'sh7FFF, 1'b0, 17'sd0, 16'sd0},
      '{16'sh0000, 16'sh0000, 16'sh8000, 1'b0, 17'sd0, 16'sd0},
      '{16'sh03E8, 16'sh0000, 16'shFFFF, 1'b0, 17'sd0, 16'sd0},
      '{16'sh0000, 16'sh7FFF, 16'sh0000, 1'b0, 17'sd0, 16'sd0},
      '{16'sh0000, 16'sh8000, 16'sh0000, 1'b0, 17'sd0, 16'sd0},
      '{16'sh0007, 16'sh0001, 16'sh0000, 1'b0, 17'sd0, 16'sd0},
      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 17'sd0, 16'sd0},
      '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 17'sd0, 16'sd0},
      '{16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0, 17'sd0, 16'sd0},
      '{16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0, 17'sd0, 16'sd0},
      '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, 17'sd0, 16'sd0},
      '{16'sh0001, 16'sh0001, 16'sh0001, 1'b0, 17'sd0, 16'sd0},
      '{16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b0, 17'sd0, 16'sd0},
      '{16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, 17'sd0, 16'sd0},
      '{16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, 17'sd0, 16'sd0},
      '{16'sh0000, 16'sh0001, 16'shFFFF, 1'b0, 17'sd0, 16'sd0},
      '{16'sh0000, 16'shFFFF, 16'shFFFF, 1'b0, 17'sd0, 16'sd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   atpr_req_if req_chan ();
   atpr_rsp_if rsp_chan ();

   accel_tilt_pitch_roll dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   atpr_pkg::res_type tilt_expect_q [$];
   int      words_sent  = 0;
   int      words_seen  = 0;
   int      err_count   = 0;
   int      cycle_count = 0;
   bit      hold_active = 1'b0;
   bit      hold_done   = 1'b0;

   // clock and reset
   always #HALF_PERIOD clock = ~clock;

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // vectoring rotation: drives vy to zero, accumulates the angle turned
   function automatic void vector_to_axis(inout longint vx, inout longint vy,
                                          inout longint ang);
      longint dx;
      longint dy;
      int     i;
      for (i = 0; i < atpr_pkg::CORDIC_STEPS; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx  += dx;
            vy  -= dy;
            ang += ATAN_STEP[i];
         end else begin
            vx  -= dx;
            vy  += dy;
            ang -= ATAN_STEP[i];
         end
      end
   endfunction

   // pitch and roll of one sample, bit exact
   function automatic atpr_pkg::res_type predict_tilt(atpr_pkg::axis_type ax,
                                                      atpr_pkg::axis_type ay,
                                                      atpr_pkg::axis_type az);
      atpr_pkg::res_type t;
      longint          vx;
      longint          vy;
      longint          ang;
      longint          rx;
      longint          ry;
      longint          rang;
      longint unsigned mag;
      longint unsigned mag_fix;
      vx  = longint'(az) <<< atpr_pkg::AXIS_SCALE_SHIFT;
      vy  = longint'(ay) <<< atpr_pkg::AXIS_SCALE_SHIFT;
      ang = 0;
      // left half plane: pre-rotate by 180 degrees
      if (az < 0) begin
         vx  = -vx;
         vy  = -vy;
         ang = (ay >= 0) ? 180 * WORK_ONE_DEG : -180 * WORK_ONE_DEG;
      end
      vector_to_axis(vx, vy, ang);
      t.pitch = atpr_pkg::pitch_type'((ang + ROUND_HALF) >>> atpr_pkg::ROUND_SHIFT);
      if (ay == 0)
         t.pitch = (az >= 0) ? atpr_pkg::pitch_type'(0)
                             : atpr_pkg::pitch_type'(180 * ONE_DEG);
      else if (az == 0)
         t.pitch = atpr_pkg::pitch_type'(((ay > 0) ? 90 : -90) * ONE_DEG);

      // undo the CORDIC gain on the magnitude, then rotate (mag, X)
      mag     = (vx > 0) ? $unsigned(vx) : 64'd0;
      mag_fix = (mag >> 30) * INV_GAIN_Q30
              + (((mag & 64'h3FFF_FFFF) * INV_GAIN_Q30) >> 30);
      rx   = $signed(mag_fix);
      ry   = longint'(ax) <<< atpr_pkg::AXIS_SCALE_SHIFT;
      rang = 0;
      vector_to_axis(rx, ry, rang);
      t.roll = atpr_pkg::roll_type'((rang + ROUND_HALF) >>> atpr_pkg::ROUND_SHIFT);
      if (ay == 0 && az == 0)
         t.roll = atpr_pkg::roll_type'((ax > 0) ? 90 * ONE_DEG
                                                : ((ax < 0) ? -90 * ONE_DEG : 0));
      return t;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void note_error(string msg);
      err_count++;
      if (err_count <= MAX_REPORTS)
         $display("ERROR cycle %0d: %s", cycle_count, msg);
   endfunction

   // offer one word and hold it until accepted
   task automatic send_word(atpr_pkg::axis_type ax, atpr_pkg::axis_type ay,
                            atpr_pkg::axis_type az, atpr_pkg::res_type want);
      req_chan.valid   <= 1'b1;
      req_chan.accel_x <= ax;
      req_chan.accel_y <= ay;
      req_chan.accel_z <= az;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tilt_expect_q.push_back(want);
      words_sent++;
   endtask

   task automatic pause_sender(int unsigned n);
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (tilt_expect_q.size() != 0) @(posedge clock);
   endtask

   // sample source
   initial begin : sample_feed
      tilt_row_type       row;
      atpr_pkg::res_type  want;
      atpr_pkg::axis_type ax;
      atpr_pkg::axis_type ay;
      atpr_pkg::axis_type az;
      int                 burst;
      int                 n;
      req_chan.valid   <= 1'b0;
      req_chan.accel_x <= '0;
      req_chan.accel_y <= '0;
      req_chan.accel_z <= '0;
      while (reset) @(posedge clock);

      // directed table
      for (n = 0; n < DIR_ROWS; n++) begin
         row = DIRECTED[n];
         if (row.known) begin
            want.pitch = row.pitch;
            want.roll  = row.roll;
         end else begin
            want = predict_tilt(row.x, row.y, row.z);
         end
         send_word(row.x, row.y, row.z, want);
         pause_sender(idle_len());
      end
      wait_drained();

      // random samples
      burst = 0;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         ax = atpr_pkg::axis_type'($urandom);
         ay = atpr_pkg::axis_type'($urandom);
         az = atpr_pkg::axis_type'($urandom);
         case ($urandom_range(0, 9)) inside
            0, 1: begin
               // near the origin
               ax = atpr_pkg::axis_type'(int'($urandom_range(0, 31)) - 16);
               ay = atpr_pkg::axis_type'(int'($urandom_range(0, 31)) - 16);
               az = atpr_pkg::axis_type'(int'($urandom_range(0, 31)) - 16);
            end
            2: ay = '0;
            3: az = '0;
            4: begin
               ay = '0;
               az = '0;
            end
            5: begin
               ax = EXTREME_VALS[$urandom_range(0, 6)];
               ay = EXTREME_VALS[$urandom_range(0, 6)];
               az = EXTREME_VALS[$urandom_range(0, 6)];
            end
            6: begin
               // close to one axis
               ax = atpr_pkg::axis_type'(int'($urandom_range(0, 63)) - 32);
               ay = atpr_pkg::axis_type'(int'($urandom_range(0, 63)) - 32);
            end
            default: ;
         endcase
         send_word(ax, ay, az, predict_tilt(ax, ay, az));
         if (n == DRAIN_AT_WORD)
            wait_drained();
         else if (hold_active)
            ;  // keep offering while the receiver holds off
         else if (burst > 0)
            burst--;
         else if ($urandom_range(0, 15) == 0)
            burst = $urandom_range(10, 40);
         else
            pause_sender(idle_len());
      end

      // drain, then let the pipeline settle
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && tilt_expect_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result receiver pacing
   initial begin : rsp_pacer
      int unsigned run;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && words_sent >= HOLD_AT_WORD) begin
            // long hold-off so the pipeline fills and stalls its input
            hold_active = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
            hold_done   = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(8, 60)) @(posedge clock);
         end else begin
            run = idle_len();
            if (run > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (run) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   end

   // compare each result word with the oldest expected angles
   always @(posedge clock) begin : tilt_check
      atpr_pkg::res_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (tilt_expect_q.size() == 0) begin
            note_error($sformatf("unexpected word pitch_deg=%0d roll_deg=%0d",
                                 rsp_chan.pitch_deg, rsp_chan.roll_deg));
         end else begin
            want = tilt_expect_q.pop_front();
            if (rsp_chan.pitch_deg !== want.pitch)
               note_error($sformatf("word %0d pitch_deg expected %0d got %0d",
                                    words_seen, want.pitch, rsp_chan.pitch_deg));
            if (rsp_chan.roll_deg !== want.roll)
               note_error($sformatf("word %0d roll_deg expected %0d got %0d",
                                    words_seen, want.roll, rsp_chan.roll_deg));
         end
         words_seen++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
